// ===== src/rgbc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rgbc_pkg
// Shared constants and types for the RGB 3x3 convolution block.
// ---------------------------------------------------------------------------
package rgbc_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COL_W          = $clog2(MAX_WIDTH);
  localparam int FILL_W         = COL_W + 1;
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int WID_W          = 12;
  localparam int HGT_W          = 13;
  localparam int KROW_W         = 48;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 12;
  localparam int PIX_W          = 24;
  localparam int Q_DEPTH        = 4;
  localparam int QCNT_W         = $clog2(Q_DEPTH + 1);
  localparam int PROD_W         = 9 + COEF_W;
  localparam int RSUM_W         = PROD_W + 2;
  localparam int TOT_W          = PROD_W + 4;

  localparam logic [WID_W-1:0] WIDTH_MIN  = WID_W'(3);
  localparam logic [WID_W-1:0] WIDTH_MAX  = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] HEIGHT_MIN = HGT_W'(3);
  localparam logic [HGT_W-1:0] HEIGHT_MAX = HGT_W'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_K_TOP  = 3'd2,
    REG_K_MID  = 3'd3,
    REG_K_BOT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
  } geom_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] newer;
    logic [PIX_W-1:0] older;
  } ram_entry_t;

  localparam int ENTRY_W = $bits(ram_entry_t);

  // taps[i*3+j]: kernel row i, column j, already mirrored at borders
  typedef struct packed {
    logic [8:0][PIX_W-1:0] taps;
    logic                  frame_end;
  } win_item_t;

endpackage
`default_nettype wire

// ===== src/rgb_3x3_convolution.sv =====
`default_nettype none
// Throughput: one request per cycle while out_ready keeps the queue from filling;
//   the queue keeps two free slots. A pixel's result needs the request one row plus
//   one pixel later, then the line store read, queue, MAC and output registers.
// Reset: synchronous, active low. Positions, window and counts clear at once;
//   the line stores are not cleared, a fill count masks entries not yet written.
// ---------------------------------------------------------------------------
// rgb_3x3_convolution
// Streaming 3x3 RGB convolution with reflect-101 borders.
// ---------------------------------------------------------------------------
module rgb_3x3_convolution import rgbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [KROW_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_func,
  input  wire logic [7:0]        in_pixel_red,
  input  wire logic [7:0]        in_pixel_green,
  input  wire logic [7:0]        in_pixel_blue,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic                   out_frame_end
);

  logic [WID_W-1:0]        width_r;
  logic [HGT_W-1:0]        height_r;
  logic [2:0][KROW_W-1:0]  kernel_r;
  geom_t                   geom;
  logic                    restart;
  logic                    push, pop, q_valid, q_room;
  win_item_t               push_item, head_item;

  assign restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_comb begin
    geom.w = (width_r < WIDTH_MIN) ? WIDTH_MIN :
             ((width_r > WIDTH_MAX) ? WIDTH_MAX : width_r);
    geom.h = (height_r < HEIGHT_MIN) ? HEIGHT_MIN :
             ((height_r > HEIGHT_MAX) ? HEIGHT_MAX : height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WID_W'(640);
      height_r    <= HGT_W'(480);
      kernel_r[0] <= '0;
      kernel_r[1] <= KROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
      kernel_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r     <= cfg_data[WID_W-1:0];
        REG_HEIGHT: height_r    <= cfg_data[HGT_W-1:0];
        REG_K_TOP:  kernel_r[0] <= cfg_data;
        REG_K_MID:  kernel_r[1] <= cfg_data;
        REG_K_BOT:  kernel_r[2] <= cfg_data;
        default:    ;
      endcase
    end
  end

  rgbc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (restart),
    .geom           (geom),
    .q_room         (q_room),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .push           (push),
    .push_item      (push_item)
  );

  rgbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (q_valid),
    .head_item (head_item),
    .room      (q_room)
  );

  rgbc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .kernel        (kernel_r),
    .q_valid       (q_valid),
    .q_item        (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire

// ===== src/rgbc_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rgbc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rgbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/rgbc_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rgbc_front
// Takes requests, tracks raster position, line stores and the 3x3 window,
// and hands mirrored windows to the queue.
// ---------------------------------------------------------------------------
module rgbc_front import rgbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       restart,
  input  wire geom_t      geom,
  input  wire logic       q_room,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_func,
  input  wire logic [7:0] in_pixel_red,
  input  wire logic [7:0] in_pixel_green,
  input  wire logic [7:0] in_pixel_blue,
  output logic            push,
  output win_item_t       push_item
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] pend_r, pend_nxt;
  logic              wv2_r, wv2_nxt;

  logic              s1_valid_r, s1_drain_r, s1_inrange_r, s1_emit_r, s1_byp_r;
  logic              s1_x0_r, s1_xl_r, s1_y0_r, s1_yl_r, s1_fend_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [PIX_W-1:0]  s1_pix_r;
  ram_entry_t        byp_entry_r;

  logic [2:0][2:0][PIX_W-1:0] win_r, win_nxt;

  logic              acc, go, emit;
  logic [COL_W-1:0]  c, xo;
  logic [ROW_W-1:0]  r, yo;
  logic [ROW_W+1:0]  ytmp;
  logic [WID_W-1:0]  wm1;
  logic [HGT_W-1:0]  hm1;
  logic [FILL_W-1:0] pend_add;
  ram_entry_t        rd_raw, rd_entry, wr_entry;
  logic              s1_mid_valid;
  logic [PIX_W-1:0]  bot;
  logic [1:0]        sr, sc;

  assign in_ready = q_room;
  assign acc      = in_valid && in_ready;
  assign go       = acc && !(in_func && (pend_r == '0));

  assign wm1 = geom.w - WID_W'(1);
  assign hm1 = geom.h - HGT_W'(1);

  always_comb begin
    c = ({1'b0, col_r} >= geom.w) ? '0 : col_r;
    r = ({1'b0, row_r} >= geom.h) ? '0 : row_r;
    xo = (c != '0) ? c - COL_W'(1) : wm1[COL_W-1:0];
    // row of the window center, one row back (two when wrapping a line)
    ytmp = {2'b00, r} + {1'b0, geom.h} - ((c != '0) ? (ROW_W+2)'(1) : (ROW_W+2)'(2));
    if (ytmp >= {1'b0, geom.h}) begin
      ytmp = ytmp - {1'b0, geom.h};
    end
    yo = ytmp[ROW_W-1:0];
  end

  // window middle row valid bit, taking the item still in flight into account
  assign rd_entry     = s1_byp_r ? byp_entry_r : rd_raw;
  assign s1_mid_valid = s1_inrange_r && rd_entry.valid;
  assign emit         = s1_valid_r ? s1_mid_valid : wv2_r;

  assign pend_add = pend_r + FILL_W'(!in_func) - FILL_W'(emit);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    if (go) begin
      pend_nxt = pend_add;
      if ({1'b0, c} == fill_r) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
      if (({1'b0, c} + WID_W'(1)) >= geom.w) begin
        col_nxt = '0;
        row_nxt = (({1'b0, r} + HGT_W'(1)) >= geom.h) ? '0 : r + ROW_W'(1);
      end else begin
        col_nxt = c + COL_W'(1);
      end
      if (emit && in_func && (pend_add == '0)) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  assign wr_entry.valid = !s1_drain_r;
  assign wr_entry.newer = s1_drain_r ? '0 : s1_pix_r;
  assign wr_entry.older = rd_entry.newer;

  rgbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (wr_entry),
    .rd_en   (go),
    .rd_addr (c),
    .rd_data (rd_raw)
  );

  assign bot = s1_drain_r ? '0 : s1_pix_r;

  always_comb begin
    win_nxt = win_r;
    wv2_nxt = wv2_r;
    if (s1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
      end
      win_nxt[0][2] = rd_entry.older;
      win_nxt[1][2] = rd_entry.newer;
      win_nxt[2][2] = bot;
      wv2_nxt       = s1_mid_valid;
    end
  end

  // reflect-101 at the borders
  always_comb begin
    push_item.frame_end = s1_fend_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sr = 2'(i);
        sc = 2'(j);
        if (i == 0 && s1_y0_r) sr = 2'd2;
        if (i == 2 && s1_yl_r) sr = 2'd0;
        if (j == 0 && s1_x0_r) sc = 2'd2;
        if (j == 2 && s1_xl_r) sc = 2'd0;
        push_item.taps[i*3+j] = win_nxt[sr][sc];
      end
    end
  end

  assign push = s1_valid_r && s1_emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r      <= '0;
      row_r      <= '0;
      fill_r     <= '0;
      pend_r     <= '0;
      wv2_r      <= 1'b0;
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      fill_r     <= fill_nxt;
      pend_r     <= pend_nxt;
      wv2_r      <= wv2_nxt;
      s1_valid_r <= go;
      win_r      <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_col_r     <= c;
      s1_drain_r   <= in_func;
      s1_pix_r     <= {in_pixel_blue, in_pixel_green, in_pixel_red};
      s1_inrange_r <= {1'b0, c} < fill_r;
      s1_emit_r    <= emit;
      s1_byp_r     <= s1_valid_r && (s1_col_r == c);
      byp_entry_r  <= wr_entry;
      s1_x0_r      <= (xo == '0);
      s1_xl_r      <= ({1'b0, xo} == wm1);
      s1_y0_r      <= (yo == '0);
      s1_yl_r      <= ({1'b0, yo} == hm1);
      s1_fend_r    <= ({1'b0, yo} == hm1) && ({1'b0, xo} == wm1);
    end
  end

endmodule
`default_nettype wire

// ===== src/rgbc_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rgbc_queue
// Short FIFO of mirrored windows between front and back.
// ---------------------------------------------------------------------------
module rgbc_queue import rgbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire win_item_t  push_item,
  input  wire logic       pop,
  output logic            not_empty,
  output win_item_t       head_item,
  output logic            room
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  win_item_t         mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rp_r];
  // room for one more request plus the one in flight in the front
  assign room      = (cnt_r <= QCNT_W'(Q_DEPTH - 2));

  always_comb begin
    wp_nxt  = push ? wp_r + PTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/rgbc_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rgbc_back
// Multiply-accumulate pipeline: products, row sums, round and saturate.
// ---------------------------------------------------------------------------
module rgbc_back import rgbc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [2:0][KROW_W-1:0] kernel,
  input  wire logic                   q_valid,
  input  wire win_item_t              q_item,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        out_frame_end
);

  localparam logic signed [TOT_W-1:0] RND = TOT_W'(1) << (COEF_FRAC_BITS - 1);

  logic en;
  logic p_valid_r, s_valid_r, o_valid_r;
  logic p_fend_r, s_fend_r, o_fend_r;
  logic signed [PROD_W-1:0] prod_r [3][9];
  logic signed [RSUM_W-1:0] rsum_r [3][3];
  logic [2:0][7:0]          o_pix_r;
  logic signed [TOT_W-1:0]  tot   [3];
  logic signed [TOT_W-1:0]  rnd   [3];
  logic [2:0][7:0]          sat;

  assign en  = !o_valid_r || out_ready;
  assign pop = q_valid && en;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = TOT_W'(rsum_r[ch][0]) + TOT_W'(rsum_r[ch][1]) + TOT_W'(rsum_r[ch][2]);
      rnd[ch] = (tot[ch] + RND) >>> COEF_FRAC_BITS;
      if (tot[ch] <= 0) begin
        sat[ch] = 8'd0;
      end else if (rnd[ch] > TOT_W'(255)) begin
        sat[ch] = 8'd255;
      end else begin
        sat[ch] = rnd[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= q_valid;
      s_valid_r <= p_valid_r;
      o_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_fend_r <= q_item.frame_end;
      s_fend_r <= p_fend_r;
      o_fend_r <= s_fend_r;
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 9; k++) begin
          prod_r[ch][k] <= $signed({1'b0, q_item.taps[k][8*ch +: 8]}) *
                           $signed(kernel[k/3][COEF_W*(k%3) +: COEF_W]);
        end
        for (int i = 0; i < 3; i++) begin
          rsum_r[ch][i] <= RSUM_W'(prod_r[ch][3*i]) + RSUM_W'(prod_r[ch][3*i+1]) +
                           RSUM_W'(prod_r[ch][3*i+2]);
        end
      end
      o_pix_r <= sat;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_red       = o_pix_r[0];
  assign out_green     = o_pix_r[1];
  assign out_blue      = o_pix_r[2];
  assign out_frame_end = o_fend_r;

endmodule
`default_nettype wire
